>>> rtl/olst_pkg.sv
// olst_pkg: types, codes and helpers for the ordered list store
// used by every module of the block; depends on nothing
`timescale 1ns / 1ps
`default_nettype none

package olst_pkg;

    // sizing
    localparam int CAPACITY    = 16;
    localparam int DATA_WIDTH  = 32;
    localparam int MAX_RESULTS = 16;
    localparam int CNT_W       = $clog2(CAPACITY + 1);
    localparam int IDX_W       = $clog2(CAPACITY);
    localparam int CMP_W       = ((CNT_W > 8) ? CNT_W : 8) + 1;

    // operation codes
    localparam logic [2:0] OP_PUSH_FRONT = 3'd0;
    localparam logic [2:0] OP_PUSH_BACK  = 3'd1;
    localparam logic [2:0] OP_POP_FRONT  = 3'd2;
    localparam logic [2:0] OP_POP_BACK   = 3'd3;
    localparam logic [2:0] OP_INSERT     = 3'd4;
    localparam logic [2:0] OP_SHOW       = 3'd5;

    // status codes
    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_EMPTY  = 2'd1;
    localparam logic [1:0] ST_BOUNDS = 2'd2;
    localparam logic [1:0] ST_FULL   = 2'd3;

    typedef logic [DATA_WIDTH-1:0] t_data;

    typedef struct packed {
        logic [2:0]         operation;
        logic [7:0]         position;
        logic signed [31:0] value;
    } t_in_item;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] element;
        logic [4:0]         count;
        logic               last;
    } t_out_item;

    // what a cell loads on the next edge
    typedef enum logic [2:0] {
        CM_HOLD  = 3'd0,
        CM_LOAD  = 3'd1,
        CM_LEFT  = 3'd2,
        CM_RIGHT = 3'd3,
        CM_WRAP  = 3'd4
    } t_cell_mode;

    typedef struct packed {
        t_cell_mode mode;
    } t_cell_cmd;

    // sign-extend the input value into a stored entry
    function automatic t_data store_val(input logic [31:0] v);
        logic [DATA_WIDTH+31:0] w;
        w = {{DATA_WIDTH{v[31]}}, v};
        return w[DATA_WIDTH-1:0];
    endfunction

    // low 32 bits of a stored entry
    function automatic logic [31:0] elem_out(input t_data d);
        logic [DATA_WIDTH+31:0] w;
        w = {32'd0, d};
        return w[31:0];
    endfunction

    // low 5 bits of the element count
    function automatic logic [4:0] cnt_out(input logic [CNT_W-1:0] c);
        logic [CNT_W+4:0] w;
        w = {5'd0, c};
        return w[4:0];
    endfunction

endpackage

`default_nettype wire

>>> rtl/olst_cell.sv
// olst_cell: one storage cell of the shifting element chain
// depends on olst_pkg
`timescale 1ns / 1ps
`default_nettype none

module olst_cell
    import olst_pkg::*;
(
    input  wire logic      i_clk,
    input  wire t_cell_cmd i_cmd,
    input  wire t_data     i_new,
    input  wire t_data     i_left,
    input  wire t_data     i_right,
    input  wire t_data     i_wrap,
    output t_data          o_data
);

    t_data r_data;
    t_data n_data;

    // pick the source for this cell
    always_comb begin
        unique case (i_cmd.mode)
            CM_HOLD:  n_data = r_data;
            CM_LOAD:  n_data = i_new;
            CM_LEFT:  n_data = i_left;
            CM_RIGHT: n_data = i_right;
            CM_WRAP:  n_data = i_wrap;
            default:  n_data = r_data;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;

endmodule

`default_nettype wire

>>> rtl/ordered_list_store.sv
// ordered_list_store: bounded deque with positional insert over a chain of cells
// a push, pop or insert strobes its result in the cycle after the transfer, one item per cycle while not busy
// show strobes one element per cycle from the result register once the show state is entered; busy
// stays high while the chain rotates once through the stored elements
// synchronous active-low reset clears the count and the control; cell contents stay undefined
// depends on olst_pkg and olst_cell
`timescale 1ns / 1ps
`default_nettype none

module ordered_list_store
    import olst_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     start,
    output logic          busy,
    input  wire t_in_item i_item,
    output logic          o_strobe,
    output t_out_item     o_result
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_SHOW = 2'b10
    } t_state;

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_count, n_count;
    logic [IDX_W-1:0] r_k, n_k;
    logic             r_strobe, n_strobe;
    t_out_item        r_result, n_result;

    t_cell_cmd        w_cmd  [CAPACITY];
    t_data            w_data [CAPACITY];
    t_data            w_new;

    logic             w_accept;
    logic [CMP_W-1:0] w_cnt, w_pos, w_last_idx, w_k, w_n_last, w_idx;
    logic             w_full, w_empty;
    logic             w_put, w_take_front, w_rot;

    assign w_accept   = start && !busy;
    assign w_cnt      = CMP_W'(r_count);
    assign w_pos      = CMP_W'(i_item.position);
    assign w_last_idx = w_cnt - CMP_W'(1);
    assign w_k        = CMP_W'(r_k);
    assign w_n_last   = ((w_cnt > CMP_W'(MAX_RESULTS)) ? CMP_W'(MAX_RESULTS) : w_cnt)
                        - CMP_W'(1);
    assign w_full     = (w_cnt >= CMP_W'(CAPACITY));
    assign w_empty    = (r_count == '0);
    assign w_new      = store_val(i_item.value);
    assign w_rot      = (r_state == S_SHOW);

    // decode the transfer into a chain action and a status, or step the show stream
    always_comb begin
        w_put        = 1'b0;
        w_take_front = 1'b0;
        w_idx        = '0;
        n_count      = r_count;
        n_result     = r_result;
        n_strobe     = 1'b0;
        n_state      = r_state;
        n_k          = r_k;
        if (w_rot) begin
            // stream cell 0 while the chain rotates
            n_strobe           = (w_k < CMP_W'(MAX_RESULTS));
            n_result.status    = ST_OK;
            n_result.element   = elem_out(w_data[0]);
            n_result.count     = cnt_out(r_count);
            n_result.last      = (w_k == w_n_last);
            n_k                = r_k + IDX_W'(1);
            if (w_k == w_last_idx) begin
                n_state = S_IDLE;
                n_k     = '0;
            end
        end else if (w_accept) begin
            n_result.status  = ST_OK;
            n_result.element = '0;
            n_result.last    = 1'b1;
            n_strobe         = 1'b1;
            unique case (i_item.operation)
                OP_PUSH_FRONT: begin
                    w_idx = '0;
                    if (w_full) n_result.status = ST_FULL;
                    else w_put = 1'b1;
                end
                OP_PUSH_BACK: begin
                    w_idx = w_cnt;
                    if (w_full) n_result.status = ST_FULL;
                    else w_put = 1'b1;
                end
                OP_POP_FRONT: begin
                    if (w_empty) n_result.status = ST_EMPTY;
                    else w_take_front = 1'b1;
                end
                OP_POP_BACK: begin
                    if (w_empty) n_result.status = ST_EMPTY;
                    else n_count = r_count - CNT_W'(1);
                end
                OP_INSERT: begin
                    w_idx = (w_pos <= CMP_W'(1)) ? '0 : (w_pos - CMP_W'(1));
                    if (w_pos > w_cnt + CMP_W'(1)) n_result.status = ST_BOUNDS;
                    else if (w_full) n_result.status = ST_FULL;
                    else w_put = 1'b1;
                end
                OP_SHOW: begin
                    n_strobe = 1'b0;
                    if (!w_empty) begin
                        n_state = S_SHOW;
                        n_k     = '0;
                    end
                end
                default: ;
            endcase
            if (w_put) n_count = r_count + CNT_W'(1);
            if (w_take_front) n_count = r_count - CNT_W'(1);
            n_result.count = cnt_out(n_count);
        end
    end

    // per-cell action and the chain itself
    for (genvar gi = 0; gi < CAPACITY; gi++) begin : g_cell
        localparam logic [CMP_W-1:0] CI = CMP_W'(gi);
        t_data w_left, w_right;

        assign w_left  = (gi == 0) ? '0 : w_data[(gi == 0) ? 0 : gi - 1];
        assign w_right = (gi == CAPACITY - 1) ? '0
                         : w_data[(gi == CAPACITY - 1) ? gi : gi + 1];

        always_comb begin
            w_cmd[gi].mode = CM_HOLD;
            if (w_rot) begin
                if (CI == w_last_idx) w_cmd[gi].mode = CM_WRAP;
                else if (CI < w_last_idx) w_cmd[gi].mode = CM_RIGHT;
            end else if (w_put) begin
                if (CI == w_idx) w_cmd[gi].mode = CM_LOAD;
                else if (CI > w_idx && CI <= w_cnt) w_cmd[gi].mode = CM_LEFT;
            end else if (w_take_front) begin
                if (CI + CMP_W'(1) < w_cnt) w_cmd[gi].mode = CM_RIGHT;
            end
        end

        olst_cell u_cell (
            .i_clk   (i_clk),
            .i_cmd   (w_cmd[gi]),
            .i_new   (w_new),
            .i_left  (w_left),
            .i_right (w_right),
            .i_wrap  (w_data[0]),
            .o_data  (w_data[gi])
        );
    end

    // control and result registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_k      <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_k      <= n_k;
            r_strobe <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_result <= n_result;
    end

    assign busy     = (r_state == S_SHOW);
    assign o_strobe = r_strobe;
    assign o_result = r_result;

endmodule

`default_nettype wire

>>> rtl/olst_checker.sv
// olst_checker: port-level checks for the ordered list store, bound to the top level
// depends on olst_pkg and ordered_list_store
`timescale 1ns / 1ps
`default_nettype none

module olst_checker
    import olst_pkg::*;
(
    input wire logic      i_clk,
    input wire logic      i_rst_n,
    input wire logic      start,
    input wire logic      busy,
    input wire t_in_item  i_item,
    input wire logic      o_strobe,
    input wire t_out_item o_result
);

    // no result right after reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_strobe)
        else $error("result strobe after reset");

    // every transfer other than show answers on the next cycle with a single last result
    a_single_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_item.operation != OP_SHOW) |=> (o_strobe && o_result.last))
        else $error("missing single result");

    // a show stream has no gaps before its last element
    a_stream_dense: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_result.last) |=> o_strobe)
        else $error("gap in show stream");

    // error results carry no element and end the transfer
    a_error_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_result.status != ST_OK) |-> (o_result.last && o_result.element == '0))
        else $error("malformed error result");

endmodule

bind ordered_list_store olst_checker u_olst_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .i_item   (i_item),
    .o_strobe (o_strobe),
    .o_result (o_result)
);

`default_nettype wire

>>> dv/ordered_list_store_tb.sv
// ordered_list_store_tb: self-checking bench for the ordered list store, with a
// queue-fed driver, a strobe monitor and an in-bench model of the list
// depends on olst_pkg and ordered_list_store
`timescale 1ns / 1ps

module ordered_list_store_tb;
    import olst_pkg::*;

    localparam int RUN_LIMIT  = 300000;
    localparam int MAX_ERR_LOG = 10;

    // one queued operation with the idle odds of its phase
    typedef struct {
        t_in_item item;
        int       idle_pct;
        bit       drain;
    } t_op_slot;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      start = 1'b0;
    t_in_item  i_item = '0;
    logic      busy;
    logic      o_strobe;
    t_out_item o_result;

    t_op_slot  op_backlog[$];
    t_out_item list_replies[$];
    t_data     list_mem [CAPACITY];
    int        list_len;
    int        bad_replies;

    ordered_list_store DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_item  (i_item),
        .o_strobe(o_strobe),
        .o_result(o_result)
    );

    // clock, 12 ns period
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // list model: insert an element at a slot
    function automatic logic [1:0] list_put(input int slot, input logic signed [31:0] v);
        int s;
        s = slot;
        if (list_len >= CAPACITY) return ST_FULL;
        if (s > list_len) s = list_len;
        for (int i = list_len; i > s; i--) list_mem[i] = list_mem[i-1];
        list_mem[s] = t_data'(v);
        list_len++;
        return ST_OK;
    endfunction

    // list model: remove the element at a slot
    function automatic logic [1:0] list_take(input int slot);
        if (list_len == 0) return ST_EMPTY;
        for (int i = slot; i + 1 < list_len; i++) list_mem[i] = list_mem[i+1];
        list_len--;
        return ST_OK;
    endfunction

    // apply one operation to the model and queue the replies it causes
    task automatic model_list_op(input t_in_item it);
        t_out_item  r;
        logic [1:0] st;
        int         n;
        st = ST_OK;
        r = '0;
        case (it.operation)
            OP_PUSH_FRONT: st = list_put(0, it.value);
            OP_PUSH_BACK:  st = list_put(list_len, it.value);
            OP_POP_FRONT:  st = list_take(0);
            OP_POP_BACK:   st = (list_len == 0) ? ST_EMPTY : list_take(list_len - 1);
            OP_INSERT: begin
                if (int'(it.position) > list_len + 1)
                    st = ST_BOUNDS;
                else
                    st = list_put((it.position <= 1) ? 0 : int'(it.position) - 1, it.value);
            end
            OP_SHOW: begin
                n = (list_len > MAX_RESULTS) ? MAX_RESULTS : list_len;
                for (int k = 0; k < n; k++) begin
                    r.status  = ST_OK;
                    r.element = 32'(list_mem[k]);
                    r.count   = 5'(list_len);
                    r.last    = (k == n - 1);
                    list_replies.push_back(r);
                end
                return;
            end
            default: st = ST_OK;
        endcase
        r.status  = st;
        r.element = '0;
        r.count   = 5'(list_len);
        r.last    = 1'b1;
        list_replies.push_back(r);
    endtask

    // driver: one transfer per accepted start, fed from the backlog
    always @(posedge i_clk) begin
        logic fed;
        logic go;
        if (!i_rst_n) begin
            start <= 1'b0;
            list_len = 0;
        end else begin
            fed = start && !busy;
            if (fed) begin
                model_list_op(i_item);
                void'(op_backlog.pop_front());
            end
            if (!(start && !fed)) begin
                go = 1'b0;
                if (op_backlog.size() != 0) begin
                    go = ($urandom_range(99) >= op_backlog[0].idle_pct);
                    // drain point: hold off until every reply is back
                    if (op_backlog[0].drain && (list_replies.size() != 0 || o_strobe))
                        go = 1'b0;
                end
                if (go) begin
                    start  <= 1'b1;
                    i_item <= op_backlog[0].item;
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    // monitor: compare each strobed reply with the oldest prediction
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_strobe) begin
            if (list_replies.size() == 0) begin
                if (bad_replies < MAX_ERR_LOG)
                    $display("unexpected reply: st=%0d el=%0d cnt=%0d last=%0d",
                             o_result.status, o_result.element, o_result.count,
                             o_result.last);
                bad_replies++;
            end else begin
                want = list_replies.pop_front();
                if (o_result.status !== want.status || o_result.element !== want.element ||
                    o_result.count !== want.count || o_result.last !== want.last) begin
                    if (bad_replies < MAX_ERR_LOG)
                        $display("reply mismatch: exp st=%0d el=%0d cnt=%0d last=%0d, got st=%0d el=%0d cnt=%0d last=%0d",
                                 want.status, want.element, want.count, want.last,
                                 o_result.status, o_result.element, o_result.count,
                                 o_result.last);
                    bad_replies++;
                end
            end
        end
    end

    // stimulus generator state: tracks only the element count
    int gen_count;

    task automatic queue_op(input logic [2:0] op, input logic [7:0] pos,
                            input logic [31:0] val, input int pct, input bit drain);
        t_op_slot s;
        s.item.operation = op;
        s.item.position  = pos;
        s.item.value     = val;
        s.idle_pct       = pct;
        s.drain          = drain;
        op_backlog.push_back(s);
        case (op)
            OP_PUSH_FRONT, OP_PUSH_BACK: if (gen_count < CAPACITY) gen_count++;
            OP_INSERT:
                if (int'(pos) <= gen_count + 1 && gen_count < CAPACITY) gen_count++;
            OP_POP_FRONT, OP_POP_BACK: if (gen_count > 0) gen_count--;
            default: ;
        endcase
    endtask

    function automatic logic [31:0] pick_value();
        case ($urandom_range(15))
            0:       return 32'h8000_0000;
            1:       return 32'h7fff_ffff;
            2:       return 32'h0000_0000;
            3:       return 32'hffff_ffff;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [7:0] pick_position();
        int r;
        r = $urandom_range(9);
        if (r == 0) return 8'd0;
        if (r == 1 && gen_count + 2 <= 255) return 8'($urandom_range(255, gen_count + 2));
        return 8'($urandom_range(gen_count + 1, 0));
    endfunction

    // random ops, biased toward filling or draining the list
    function automatic logic [2:0] pick_op(input bit filling);
        int r;
        r = $urandom_range(99);
        if (filling) begin
            if (r < 30) return OP_PUSH_BACK;
            if (r < 50) return OP_PUSH_FRONT;
            if (r < 75) return OP_INSERT;
            if (r < 85) return OP_POP_FRONT;
            if (r < 93) return OP_POP_BACK;
            if (r < 99) return OP_SHOW;
        end else begin
            if (r < 12) return OP_PUSH_BACK;
            if (r < 20) return OP_PUSH_FRONT;
            if (r < 30) return OP_INSERT;
            if (r < 60) return OP_POP_FRONT;
            if (r < 88) return OP_POP_BACK;
            if (r < 98) return OP_SHOW;
        end
        return 3'($urandom_range(7, 6));
    endfunction

    // run limit
    initial begin
        for (int cyc = 0; cyc < RUN_LIMIT; cyc++) @(posedge i_clk);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // reset, stimulus and end of run
    initial begin
        int phase_pct [4];
        bit filling;
        int made;
        logic [2:0] op;
        phase_pct = '{0, 48, 0, 24};
        bad_replies = 0;
        gen_count = 0;

        // directed: empty list cases, extremes, every operation
        queue_op(OP_SHOW,       8'd0,   32'd0,         0, 1'b0);
        queue_op(OP_POP_FRONT,  8'd0,   32'd0,         0, 1'b0);
        queue_op(OP_POP_BACK,   8'd0,   32'd0,         0, 1'b0);
        queue_op(OP_INSERT,     8'd2,   32'd5,         0, 1'b0);
        queue_op(3'd6,          8'hff,  32'hffff_ffff, 0, 1'b0);
        queue_op(OP_PUSH_FRONT, 8'd0,   32'h8000_0000, 0, 1'b0);
        queue_op(OP_PUSH_BACK,  8'd0,   32'h7fff_ffff, 0, 1'b0);
        queue_op(OP_INSERT,     8'd0,   32'hffff_ffff, 0, 1'b0);
        queue_op(OP_INSERT,     8'd1,   32'h0000_0000, 0, 1'b0);
        queue_op(OP_INSERT,     8'd3,   32'h1234_5678, 0, 1'b0);
        queue_op(OP_INSERT,     8'd6,   32'h5555_aaaa, 0, 1'b0);
        queue_op(OP_SHOW,       8'd0,   32'd0,         0, 1'b0);
        queue_op(3'd7,          8'd0,   32'd0,         0, 1'b0);
        queue_op(OP_POP_FRONT,  8'd0,   32'd0,         0, 1'b0);
        queue_op(OP_POP_BACK,   8'd0,   32'd0,         0, 1'b0);
        // fill to capacity, then hit the full and out-of-range cases
        while (gen_count < CAPACITY)
            queue_op(OP_PUSH_BACK, 8'd0, pick_value(), 0, 1'b0);
        queue_op(OP_PUSH_FRONT, 8'd0,   32'd1,         0, 1'b0);
        queue_op(OP_INSERT,     8'(CAPACITY + 1), 32'd2, 0, 1'b0);
        queue_op(OP_INSERT,     8'(CAPACITY + 2), 32'd3, 0, 1'b0);
        queue_op(OP_INSERT,     8'd255, 32'd4,         0, 1'b0);
        queue_op(OP_SHOW,       8'd0,   32'd0,         0, 1'b0);

        // random phases, each opening with a drain point
        filling = 1'b0;
        for (int ph = 0; ph < 4; ph++) begin
            made = 0;
            while (made < 88) begin
                if (filling && gen_count == CAPACITY && $urandom_range(3) == 0)
                    filling = 1'b0;
                else if (!filling && gen_count == 0 && $urandom_range(2) == 0)
                    filling = 1'b1;
                op = pick_op(filling);
                queue_op(op, pick_position(), pick_value(), phase_pct[ph],
                         (made == 0) || ($urandom_range(39) == 0));
                if (op <= OP_SHOW) made++;
            end
        end

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (op_backlog.size() != 0 || start || list_replies.size() != 0)
            @(posedge i_clk);
        repeat (MAX_RESULTS + 8) @(posedge i_clk);

        if (bad_replies == 0 && list_replies.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

>>> ordered_list_store.f
rtl/olst_pkg.sv
rtl/olst_cell.sv
rtl/ordered_list_store.sv
rtl/olst_checker.sv
dv/ordered_list_store_tb.sv
